[rtl/hashed_session_table_core_macros.svh]
// Assertion macros shared by the session table RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef HASHED_SESSION_TABLE_CORE_MACROS_SVH
`define HASHED_SESSION_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define HST_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HST_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hst_pkg.sv]
// Types and constants for the hashed session table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hst_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int WAYS_DEF    = 4;
    localparam int QDEPTH      = 4;

    localparam int KEY_W    = 31;
    localparam int HANDLE_W = 16;
    localparam int ROOM_W   = 31;
    localparam int TOTAL_W  = 9;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 9'd511;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_LOOKUP = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_ABSENT  = 2'd1;
    localparam logic [1:0] STAT_PRESENT = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [ROOM_W-1:0]   room;
    } req_t;

    typedef struct packed {
        logic                vld;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [ROOM_W-1:0]   room;
    } way_t;

endpackage

`default_nettype wire

[rtl/hst_ram.sv]
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/hst_front.sv]
// Front end: registers a request and works out its bucket (key mod BUCKETS)
// by reciprocal multiply and one correction. Depends on hst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hst_front #(
    parameter int BUCKETS = hst_pkg::BUCKETS_DEF,
    parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire hst_pkg::req_t req_in,
    output logic               push,
    output hst_pkg::req_t      push_req,
    output logic [BW-1:0]      push_bucket
);

    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / 64'(BUCKETS));
    localparam logic [BW:0] BKT   = (BW+1)'(BUCKETS);

    logic          v1_reg, v2_reg, v3_reg;
    hst_pkg::req_t req1_reg, req2_reg, req3_reg;
    logic [30:0]   q2_reg, qb3_reg;

    logic [62:0] prod;
    logic [43:0] qb_full;
    logic [30:0] diff;
    logic [BW:0] rem;
    logic [BW:0] rem_fix;

    assign prod    = 63'(req1_reg.key) * 63'(RECIP);
    assign qb_full = 44'(q2_reg) * 44'(BUCKETS);
    assign diff    = req3_reg.key - qb3_reg;
    assign rem     = diff[BW:0];
    assign rem_fix = (rem >= BKT) ? rem - BKT : rem;

    assign push        = v3_reg;
    assign push_req    = req3_reg;
    assign push_bucket = rem_fix[BW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        req1_reg <= req_in;
        req2_reg <= req1_reg;
        q2_reg   <= prod[61:31];
        req3_reg <= req2_reg;
        qb3_reg  <= qb_full[30:0];
    end

endmodule

`default_nettype wire

[rtl/hst_queue.sv]
// Short request queue between the front end and the table engine.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_session_table_core_macros.svh"

module hst_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4,
    parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    input  wire logic          pop,
    output logic               not_empty,
    output logic      [DW-1:0] head
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `HST_ASSERT_IMPL(a_no_overflow, push, count_reg != CW'(DEPTH) || pop, "queue overflow")
    `HST_ASSERT_IMPL(a_no_underflow, pop, count_reg != '0, "pop from empty queue")

endmodule

`default_nettype wire

[rtl/hst_back.sv]
// Table engine: clears the bucket RAM after reset, then reads a bucket,
// compares all ways and writes back any change. Depends on hst_pkg, hst_ram, macros.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_session_table_core_macros.svh"

module hst_back #(
    parameter int BUCKETS = hst_pkg::BUCKETS_DEF,
    parameter int WAYS    = hst_pkg::WAYS_DEF,
    parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire hst_pkg::req_t                 q_req,
    input  wire logic [BW-1:0]                 q_bucket,
    output logic                               pop,
    output logic                               clearing,
    output logic                               done,
    output logic [1:0]                         status,
    output logic                               present,
    output logic [hst_pkg::ROOM_W-1:0]         room_out,
    output logic [hst_pkg::HANDLE_W-1:0]       handle_out,
    output logic [hst_pkg::TOTAL_W-1:0]        occupancy
);

    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * $bits(hst_pkg::way_t);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [BW-1:0] clr_addr_reg, clr_addr_next;
    logic [hst_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic          done_reg;

    hst_pkg::req_t op_reg;
    logic [BW-1:0] bkt_reg;

    logic [1:0]                    status_reg, status_next;
    logic                          present_reg;
    logic [hst_pkg::ROOM_W-1:0]    room_reg, room_next;
    logic [hst_pkg::HANDLE_W-1:0]  handle_reg, handle_next;

    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] ram_wdata;
    logic [BW-1:0]    ram_waddr;
    logic             ram_we;

    hst_pkg::way_t [WAYS-1:0] row_rd;
    hst_pkg::way_t [WAYS-1:0] row_wr;

    logic [WAYS-1:0] hit_vec, free_vec, hit_one, free_one;
    logic [WW-1:0]   hit_idx, free_idx;
    logic            hit_any, free_any;
    logic            exec_wr;

    hst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS),
        .AW    (BW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (q_bucket),
        .rdata (ram_rdata)
    );

    assign row_rd = ram_rdata;

    assign pop        = (state_reg == S_IDLE) && q_valid;
    assign clearing   = (state_reg == S_CLEAR);
    assign done       = done_reg;
    assign status     = status_reg;
    assign present    = present_reg;
    assign room_out   = room_reg;
    assign handle_out = handle_reg;
    assign occupancy  = total_reg;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w]  = row_rd[w].vld && (row_rd[w].key == op_reg.key);
            free_vec[w] = !row_rd[w].vld;
        end
        hit_one  = hit_vec & (~hit_vec + 1'b1);
        free_one = free_vec & (~free_vec + 1'b1);
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_idx  = hit_idx | (hit_one[w] ? WW'(w) : '0);
            free_idx = free_idx | (free_one[w] ? WW'(w) : '0);
        end
        hit_any  = |hit_vec;
        free_any = |free_vec;
    end

    always_comb
    begin
        row_wr      = row_rd;
        exec_wr     = 1'b0;
        status_next = hst_pkg::STAT_ABSENT;
        room_next   = '0;
        handle_next = hit_any ? row_rd[hit_idx].handle : '0;
        total_next  = total_reg;
        case (op_reg.mode)
            hst_pkg::MODE_INSERT:
            begin
                if (hit_any)
                begin
                    status_next = hst_pkg::STAT_PRESENT;
                end
                else if (!free_any)
                begin
                    status_next = hst_pkg::STAT_FULL;
                end
                else
                begin
                    row_wr[free_idx].vld    = 1'b1;
                    row_wr[free_idx].key    = op_reg.key;
                    row_wr[free_idx].handle = op_reg.handle;
                    row_wr[free_idx].room   = op_reg.room;
                    exec_wr     = 1'b1;
                    status_next = hst_pkg::STAT_DONE;
                    if (total_reg != hst_pkg::TOTAL_MAX)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                end
            end
            hst_pkg::MODE_DELETE:
            begin
                if (hit_any)
                begin
                    row_wr[hit_idx].vld = 1'b0;
                    exec_wr     = 1'b1;
                    status_next = hst_pkg::STAT_DONE;
                    if (total_reg != '0)
                    begin
                        total_next = total_reg - 1'b1;
                    end
                end
            end
            hst_pkg::MODE_UPDATE:
            begin
                if (hit_any)
                begin
                    row_wr[hit_idx].room = op_reg.room;
                    exec_wr     = 1'b1;
                    status_next = hst_pkg::STAT_DONE;
                end
            end
            hst_pkg::MODE_LOOKUP:
            begin
                if (hit_any)
                begin
                    room_next   = row_rd[hit_idx].room;
                    status_next = hst_pkg::STAT_DONE;
                end
            end
            default:
            begin
                status_next = hst_pkg::STAT_ABSENT;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = bkt_reg;
        ram_wdata = row_wr;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_EXEC)
        begin
            ram_we = exec_wr;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            total_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= (state_reg == S_EXEC);
            if (state_reg == S_EXEC)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg  <= q_req;
            bkt_reg <= q_bucket;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg  <= status_next;
            present_reg <= hit_any;
            room_reg    <= room_next;
            handle_reg  <= handle_next;
        end
    end

    `HST_ASSERT_IMPL(a_pop_when_idle, pop, state_reg == S_IDLE && q_valid, "pop outside idle")
    `HST_ASSERT_NEXT(a_exec_reports, state_reg == S_EXEC, done_reg, "request without result")
    `HST_ASSERT_NEXT(a_total_on_exec, state_reg != S_EXEC, $stable(total_reg), "stray count change")

endmodule

`default_nettype wire

[rtl/hashed_session_table_core.sv]
// An accepted request passes the front end registers, the queue and the
// table engine before its done strobe. The engine takes one request at a time:
// it reads the bucket from the RAM port, then compares and writes back any change.
// Up to 4 requests may wait ahead of the table engine; busy is high while 4 do.
// After reset the bucket RAM is cleared, one bucket a cycle, and busy is high
// while it is. Results are strobed for one cycle and cannot be held.
`timescale 1ns / 1ps
`default_nettype none

module hashed_session_table_core #(
    parameter int BUCKETS = hst_pkg::BUCKETS_DEF,
    parameter int WAYS    = hst_pkg::WAYS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   mode,
    input  wire logic [hst_pkg::KEY_W-1:0]    user_key,
    input  wire logic [hst_pkg::HANDLE_W-1:0] conn_handle,
    input  wire logic [hst_pkg::ROOM_W-1:0]   room,
    output logic                              done,
    output logic [1:0]                        status,
    output logic                              present,
    output logic [hst_pkg::ROOM_W-1:0]        room_out,
    output logic [hst_pkg::HANDLE_W-1:0]      handle_out,
    output logic [hst_pkg::TOTAL_W-1:0]       occupancy
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW = $bits(hst_pkg::req_t);
    localparam int DW = RW + BW;
    localparam int FW = $clog2(hst_pkg::QDEPTH + 1);

    hst_pkg::req_t req_in;
    logic          accept;
    logic          push;
    hst_pkg::req_t push_req;
    logic [BW-1:0] push_bucket;
    logic          pop;
    logic          q_valid;
    logic [DW-1:0] q_head;
    logic          clearing;

    logic [FW-1:0] inflight_reg, inflight_next;

    assign req_in.mode   = mode;
    assign req_in.key    = user_key;
    assign req_in.handle = conn_handle;
    assign req_in.room   = room;

    assign busy   = clearing || (inflight_reg == FW'(hst_pkg::QDEPTH));
    assign accept = start && !busy;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (accept && !pop)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (pop && !accept)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    hst_front #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_in      (req_in),
        .push        (push),
        .push_req    (push_req),
        .push_bucket (push_bucket)
    );

    hst_queue #(
        .DW    (DW),
        .DEPTH (hst_pkg::QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_bucket, push_req}),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    hst_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .BW      (BW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_req      (q_head[RW-1:0]),
        .q_bucket   (q_head[DW-1:RW]),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .status     (status),
        .present    (present),
        .room_out   (room_out),
        .handle_out (handle_out),
        .occupancy  (occupancy)
    );

endmodule

`default_nettype wire

[bench/session_table_checker.sv]
// Checker for the hashed session table: watches the request and result channels,
// predicts each result from its own copy of the table and compares field by field.
// Depends on hst_pkg.
`timescale 1ns / 1ps

module session_table_checker #(
    parameter int BUCKETS = hst_pkg::BUCKETS_DEF,
    parameter int WAYS    = hst_pkg::WAYS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic [1:0]                   mode,
    input  wire logic [hst_pkg::KEY_W-1:0]    user_key,
    input  wire logic [hst_pkg::HANDLE_W-1:0] conn_handle,
    input  wire logic [hst_pkg::ROOM_W-1:0]   room,
    input  wire logic                         done,
    input  wire logic [1:0]                   status,
    input  wire logic                         present,
    input  wire logic [hst_pkg::ROOM_W-1:0]   room_out,
    input  wire logic [hst_pkg::HANDLE_W-1:0] handle_out,
    input  wire logic [hst_pkg::TOTAL_W-1:0]  occupancy,
    output int                                fail_count,
    output int                                pending
);

    import hst_pkg::*;

    localparam int ENTRIES = BUCKETS * WAYS;

    typedef struct packed {
        logic [1:0]          status;
        logic                present;
        logic [ROOM_W-1:0]   room;
        logic [HANDLE_W-1:0] handle;
        logic [TOTAL_W-1:0]  occupancy;
    } table_result_t;

    logic                slot_valid  [ENTRIES];
    logic [KEY_W-1:0]    slot_key    [ENTRIES];
    logic [HANDLE_W-1:0] slot_handle [ENTRIES];
    logic [ROOM_W-1:0]   slot_room   [ENTRIES];
    logic [TOTAL_W-1:0]  entry_count;

    table_result_t expected_results[$];
    table_result_t oldest;
    int            errors;

    function automatic table_result_t apply_request(
        input logic [1:0]          op,
        input logic [KEY_W-1:0]    key,
        input logic [HANDLE_W-1:0] handle,
        input logic [ROOM_W-1:0]   new_room
    );
        int            base;
        int            hit;
        int            free_way;
        table_result_t res;
        base     = int'(key % BUCKETS) * WAYS;
        hit      = -1;
        free_way = -1;
        res      = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (slot_valid[base + w])
            begin
                if (hit < 0 && slot_key[base + w] == key)
                    hit = w;
            end
            else if (free_way < 0)
            begin
                free_way = w;
            end
        end
        if (hit >= 0)
        begin
            res.present = 1'b1;
            res.handle  = slot_handle[base + hit];
        end
        case (op)
            MODE_INSERT:
            begin
                if (hit >= 0)
                    res.status = STAT_PRESENT;
                else if (free_way < 0)
                    res.status = STAT_FULL;
                else
                begin
                    slot_valid[base + free_way]  = 1'b1;
                    slot_key[base + free_way]    = key;
                    slot_handle[base + free_way] = handle;
                    slot_room[base + free_way]   = new_room;
                    if (entry_count < TOTAL_MAX)
                        entry_count++;
                    res.status = STAT_DONE;
                end
            end
            MODE_DELETE:
            begin
                if (hit >= 0)
                begin
                    slot_valid[base + hit] = 1'b0;
                    if (entry_count > 0)
                        entry_count--;
                    res.status = STAT_DONE;
                end
                else
                    res.status = STAT_ABSENT;
            end
            MODE_UPDATE:
            begin
                if (hit >= 0)
                begin
                    slot_room[base + hit] = new_room;
                    res.status = STAT_DONE;
                end
                else
                    res.status = STAT_ABSENT;
            end
            default:
            begin
                if (hit >= 0)
                begin
                    res.room   = slot_room[base + hit];
                    res.status = STAT_DONE;
                end
                else
                    res.status = STAT_ABSENT;
            end
        endcase
        res.occupancy = entry_count;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                slot_valid[i] = 1'b0;
            entry_count = '0;
            expected_results.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // the strobe always belongs to an older request than one accepted now
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result strobe with no request outstanding", $time);
                    errors++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("status", 32'(oldest.status), 32'(status));
                    check_field("present", 32'(oldest.present), 32'(present));
                    check_field("room_out", 32'(oldest.room), 32'(room_out));
                    check_field("handle_out", 32'(oldest.handle), 32'(handle_out));
                    check_field("occupancy", 32'(oldest.occupancy), 32'(occupancy));
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_request(mode, user_key, conn_handle, room));
            pending <= expected_results.size();
            fail_count <= errors;
        end
    end

endmodule

[bench/testbench.sv]
// Top of the session table bench: clock, reset, request stimulus and verdict.
// Depends on hst_pkg, hashed_session_table_core and session_table_checker.
`timescale 1ns / 1ps

module testbench;

    import hst_pkg::*;

    localparam int BUCKETS     = 64;
    localparam int WAYS        = 4;
    localparam int ITEM_TARGET = 1700;
    localparam int IDLE_LIMIT  = 4000;
    localparam int POOL_MAX    = 400;

    localparam logic [KEY_W-1:0]    KEY_MAX    = '1;
    localparam logic [ROOM_W-1:0]   ROOM_MAX   = '1;
    localparam logic [HANDLE_W-1:0] HANDLE_MAX = '1;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic [1:0]          mode        = MODE_LOOKUP;
    logic [KEY_W-1:0]    user_key    = '0;
    logic [HANDLE_W-1:0] conn_handle = '0;
    logic [ROOM_W-1:0]   room        = '0;

    logic                busy;
    logic                done;
    logic [1:0]          status;
    logic                present;
    logic [ROOM_W-1:0]   room_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [TOTAL_W-1:0]  occupancy;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    logic [KEY_W-1:0] key_pool [POOL_MAX];
    int               pool_size;

    hashed_session_table_core #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .user_key    (user_key),
        .conn_handle (conn_handle),
        .room        (room),
        .done        (done),
        .status      (status),
        .present     (present),
        .room_out    (room_out),
        .handle_out  (handle_out),
        .occupancy   (occupancy)
    );

    session_table_checker #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .user_key    (user_key),
        .conn_handle (conn_handle),
        .room        (room),
        .done        (done),
        .status      (status),
        .present     (present),
        .room_out    (room_out),
        .handle_out  (handle_out),
        .occupancy   (occupancy),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [KEY_W-1:0] key_in_bucket(input int bucket);
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        return KEY_W'(k - (k % BUCKETS) + bucket);
    endfunction

    function automatic logic [HANDLE_W-1:0] random_handle();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return HANDLE_MAX;
            default: return HANDLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [ROOM_W-1:0] random_room();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ROOM_MAX;
            default: return ROOM_W'($urandom);
        endcase
    endfunction

    // bursts of back-to-back requests separated by random gaps
    task automatic send(input logic [1:0] op, input logic [KEY_W-1:0] key,
                        input logic [HANDLE_W-1:0] handle, input logic [ROOM_W-1:0] rm);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
        end
        start       <= 1'b1;
        mode        <= op;
        user_key    <= key;
        conn_handle <= handle;
        room        <= rm;
        do
            @(posedge clk);
        while (busy);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int               buckets_used;
        int               first_bucket;
        int               insert_pct;
        int               phase_len;
        logic [1:0]       op;
        logic [KEY_W-1:0] key;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send(MODE_LOOKUP, '0, '0, '0);
        send(MODE_DELETE, '0, '0, '0);
        send(MODE_UPDATE, '0, '0, ROOM_MAX);
        send(MODE_INSERT, '0, '0, '0);
        send(MODE_INSERT, KEY_MAX, HANDLE_MAX, ROOM_MAX);
        send(MODE_LOOKUP, KEY_MAX, '0, '0);
        send(MODE_LOOKUP, '0, HANDLE_MAX, ROOM_MAX);
        send(MODE_INSERT, '0, 16'h1234, 31'd5);
        send(MODE_UPDATE, KEY_MAX, '0, '0);
        send(MODE_LOOKUP, KEY_MAX, '0, '0);
        send(MODE_INSERT, 31'd64, 16'haaaa, 31'h5555_5555);
        send(MODE_INSERT, 31'd128, 16'h5555, 31'h2aaa_aaaa);
        send(MODE_INSERT, 31'd192, 16'h0001, 31'd1);
        send(MODE_INSERT, 31'd256, 16'h8000, 31'h4000_0000);
        send(MODE_LOOKUP, 31'd256, '0, '0);
        send(MODE_DELETE, 31'd64, '0, '0);
        send(MODE_INSERT, 31'd256, 16'h8000, 31'h4000_0000);
        send(MODE_LOOKUP, 31'd256, '0, '0);
        send(MODE_DELETE, '0, '0, '0);
        send(MODE_DELETE, '0, '0, '0);
        send(MODE_UPDATE, 31'd128, '0, ROOM_MAX);
        send(MODE_LOOKUP, 31'd128, '0, '0);
        send(MODE_LOOKUP, KEY_MAX - 31'd63, '0, '0);
        drain();

        // phases over a few crowded buckets or the whole table
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0:       buckets_used = 1;
                1:       buckets_used = 3;
                2:       buckets_used = 8;
                default: buckets_used = BUCKETS;
            endcase
            case ($urandom_range(0, 3))
                0:       insert_pct = 10;
                1:       insert_pct = 40;
                2:       insert_pct = 60;
                default: insert_pct = 90;
            endcase
            first_bucket = $urandom_range(0, BUCKETS - 1);
            pool_size    = buckets_used * 6;
            for (int i = 0; i < pool_size; i++)
                key_pool[i] = key_in_bucket((first_bucket + i % buckets_used) % BUCKETS);
            phase_len = $urandom_range(80, 220);
            for (int n = 0; n < phase_len; n++)
            begin
                if ($urandom_range(0, 99) < 5)
                begin
                    op  = 2'($urandom_range(0, 3));
                    key = KEY_W'($urandom);
                end
                else
                begin
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                    if ($urandom_range(0, 99) < insert_pct)
                        op = MODE_INSERT;
                    else
                    begin
                        case ($urandom_range(0, 2))
                            0:       op = MODE_DELETE;
                            1:       op = MODE_UPDATE;
                            default: op = MODE_LOOKUP;
                        endcase
                    end
                end
                send(op, key, random_handle(), random_room());
            end
            drain();
        end

        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[hashed_session_table_core.f]
+incdir+rtl
rtl/hst_pkg.sv
rtl/hst_ram.sv
rtl/hst_front.sv
rtl/hst_queue.sv
rtl/hst_back.sv
rtl/hashed_session_table_core.sv
bench/session_table_checker.sv
bench/testbench.sv
